/* rtl/core/hgsc_pkg.sv */
// Shared types, constants and helpers for the heat grid stencil block.
package hgsc_pkg;

  localparam int ROWS = 8;
  localparam int COLS = 8;

  // Grid index space is fixed by the 3-bit row and column fields.
  localparam int CELL_AW     = 6;
  localparam int GRID_SLOTS  = 1 << CELL_AW;
  localparam int BOTTOM_SLOTS = 8;

  // Front queue depth, power of two.
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam int COEF_W   = 12;
  localparam int CFG_W    = 36;

  localparam logic [2:0] LAST_ROW = 3'(ROWS - 1);
  localparam logic [2:0] LAST_COL = 3'(COLS - 1);

  // Command codes
  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_COEF_TOP    = 2'd0;
  localparam logic [1:0] CFG_COEF_MIDDLE = 2'd1;
  localparam logic [1:0] CFG_COEF_BOTTOM = 2'd2;
  localparam logic [1:0] CFG_COOLING     = 2'd3;

  typedef struct packed {
    logic       command;
    logic [2:0] column;
    logic [7:0] heat;
  } in_word_t;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
    logic [7:0] new_heat;
    logic       last;
  } out_word_t;

  // Decoded job handed from front to back
  typedef struct packed {
    logic       is_step;
    logic [2:0] column;
    logic [7:0] heat;
  } job_t;

  typedef struct packed {
    logic [CFG_W-1:0] coef_top;
    logic [CFG_W-1:0] coef_middle;
    logic [CFG_W-1:0] coef_bottom;
    logic [7:0]       cooling;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TAPS,
    ST_DRAIN,
    ST_FINISH
  } back_state_t;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_GRID,
    SRC_BOTTOM
  } tap_src_t;

  function automatic logic [CELL_AW-1:0] cell_index(logic [2:0] r, logic [2:0] c);
    return CELL_AW'(r * COLS) + CELL_AW'(c);
  endfunction

endpackage

/* rtl/core/heat_grid_stencil_cooling.sv */
// Top level: configuration registers, front decoder/queue and stencil back end.
// Order: a set word writes the bottom row when the idle back end takes it from
//   the queue; a step emits one cell word per cell after its tap reads, pipeline
//   drain and finish, and the finish waits while the output is stalled.
// Serialisation: steps run one at a time, limited by the single grid memory
//   read port and the one shared multiply-accumulate.
// Reset: synchronous active low; clears coefficients, cooling, bottom row and
//   marks the grid as all zero at once, so no clearing pass is needed.
module heat_grid_stencil_cooling import hgsc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  // input word channel
  input  logic             in_valid,
  output logic             in_stall,
  input  in_word_t         in_data,
  // result word channel
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_data,
  // configuration writes
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  cfg_t cfg_r;
  logic job_valid;
  job_t job;
  logic job_take;

  // Coefficient words hold three 12-bit signed taps: left, centre, right.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COEF_TOP:    cfg_r.coef_top    <= cfg_wdata;
        CFG_COEF_MIDDLE: cfg_r.coef_middle <= cfg_wdata;
        CFG_COEF_BOTTOM: cfg_r.coef_bottom <= cfg_wdata;
        CFG_COOLING:     cfg_r.cooling     <= cfg_wdata[7:0];
        default:         cfg_r             <= cfg_r;
      endcase
    end
  end

  // Front: accepts words even while the back end is mid-step, until its queue is full.
  hgsc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take)
  );

  // Back: ping-pong grid banks so every cell of a step sees the old grid.
  hgsc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* rtl/core/hgsc_front.sv */
// Front end: takes input words, decodes the command and queues jobs.
module hgsc_front import hgsc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_data,
  output logic     job_valid,
  output job_t     job,
  input  logic     job_take
);

  job_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              push;
  logic              pop;
  job_t              decoded;

  always_comb begin
    decoded.is_step = (in_data.command == CMD_STEP);
    decoded.column  = in_data.column;
    decoded.heat    = in_data.heat;
  end

  assign in_stall  = (count_r == QCNT_W'(QDEPTH));
  assign push      = in_valid && !in_stall;
  assign job_valid = (count_r != '0);
  assign pop       = job_take && job_valid;
  assign job       = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* rtl/core/hgsc_back.sv */
// Back end: bottom row writes and the per-cell 3x3 stencil sequencer.
module hgsc_back import hgsc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_valid,
  input  job_t      job,
  output logic      job_take,
  input  cfg_t      cfg,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam logic signed [4:0] ROWS_S = 5'(ROWS);
  localparam logic signed [4:0] COLS_S = 5'(COLS);

  back_state_t state_r, state_nxt;
  logic [2:0]  row_r, row_nxt;
  logic [2:0]  col_r, col_nxt;
  logic [1:0]  tap_dr_r, tap_dr_nxt;
  logic [1:0]  tap_dc_r, tap_dc_nxt;
  logic        bank_r;
  logic        grid_clr_r;

  logic [7:0]  bottom_r [BOTTOM_SLOTS];
  logic [7:0]  grid_mem [2*GRID_SLOTS];
  logic [7:0]  mem_q_r;
  logic [7:0]  bot_q_r;

  logic                      s1_v_r;
  tap_src_t                  s1_src_r;
  logic signed [COEF_W-1:0]  s1_coef_r;
  logic                      s1_centre_r;
  logic                      s2_v_r;
  logic signed [20:0]        s2_prod_r;
  logic signed [23:0]        acc_r;
  logic [7:0]                centre_r;

  logic        out_valid_r;
  out_word_t   out_r;

  logic        issue;
  logic        acc_clr;
  logic        fire;
  logic        last_cell;

  logic signed [4:0]        tap_row;
  logic signed [4:0]        tap_col;
  tap_src_t                 tap_src;
  logic [CFG_W-1:0]         coef_row;
  logic signed [COEF_W-1:0] tap_coef;
  logic [7:0]               s1_data;
  logic signed [23:0]       acc_bias;
  logic [7:0]               raw_heat;
  logic [7:0]               cooled;

  // Tap coordinates and source
  always_comb begin
    tap_row = $signed({2'b00, row_r}) + $signed({3'b000, tap_dr_r}) - 5'sd1;
    tap_col = $signed({2'b00, col_r}) + $signed({3'b000, tap_dc_r}) - 5'sd1;
    if (tap_col < 5'sd0 || tap_col >= COLS_S || tap_row < 5'sd0 || tap_row > ROWS_S) begin
      tap_src = SRC_ZERO;
    end else if (tap_row == ROWS_S) begin
      tap_src = SRC_BOTTOM;
    end else begin
      tap_src = SRC_GRID;
    end
  end

  always_comb begin
    case (tap_dr_r)
      2'd0:    coef_row = cfg.coef_top;
      2'd1:    coef_row = cfg.coef_middle;
      default: coef_row = cfg.coef_bottom;
    endcase
    case (tap_dc_r)
      2'd0:    tap_coef = $signed(coef_row[11:0]);
      2'd1:    tap_coef = $signed(coef_row[23:12]);
      default: tap_coef = $signed(coef_row[35:24]);
    endcase
  end

  // Stage 1 data: grid reads as zero until the first step has finished
  always_comb begin
    case (s1_src_r)
      SRC_GRID:   s1_data = grid_clr_r ? 8'd0 : mem_q_r;
      SRC_BOTTOM: s1_data = bot_q_r;
      default:    s1_data = 8'd0;
    endcase
  end

  // Divide by 256 toward zero, add modulo 256, then cool
  always_comb begin
    acc_bias = acc_r + (acc_r[23] ? 24'sd255 : 24'sd0);
    raw_heat = centre_r + acc_bias[15:8];
    cooled   = (raw_heat > cfg.cooling) ? (raw_heat - cfg.cooling) : 8'd0;
  end

  assign last_cell = (row_r == LAST_ROW) && (col_r == LAST_COL);

  always_comb begin
    state_nxt  = state_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    tap_dr_nxt = tap_dr_r;
    tap_dc_nxt = tap_dc_r;
    job_take   = 1'b0;
    issue      = 1'b0;
    acc_clr    = 1'b0;
    fire       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          job_take = 1'b1;
          if (job.is_step) begin
            row_nxt    = 3'd0;
            col_nxt    = 3'd0;
            tap_dr_nxt = 2'd0;
            tap_dc_nxt = 2'd0;
            acc_clr    = 1'b1;
            state_nxt  = ST_TAPS;
          end
        end
      end
      ST_TAPS: begin
        issue = 1'b1;
        if (tap_dc_r == 2'd2) begin
          tap_dc_nxt = 2'd0;
          if (tap_dr_r == 2'd2) begin
            tap_dr_nxt = 2'd0;
            state_nxt  = ST_DRAIN;
          end else begin
            tap_dr_nxt = tap_dr_r + 2'd1;
          end
        end else begin
          tap_dc_nxt = tap_dc_r + 2'd1;
        end
      end
      ST_DRAIN: begin
        if (!s1_v_r && !s2_v_r) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          fire    = 1'b1;
          acc_clr = 1'b1;
          if (last_cell) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_TAPS;
            if (col_r == LAST_COL) begin
              col_nxt = 3'd0;
              row_nxt = row_r + 3'd1;
            end else begin
              col_nxt = col_r + 3'd1;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Grid memory: old grid in bank_r, new grid written to the other bank
  always_ff @(posedge clk) begin
    if (fire) begin
      grid_mem[{~bank_r, cell_index(row_r, col_r)}] <= cooled;
    end
    mem_q_r <= grid_mem[{bank_r, cell_index(tap_row[2:0], tap_col[2:0])}];
  end

  always_ff @(posedge clk) begin
    bot_q_r   <= bottom_r[tap_col[2:0]];
    s1_src_r  <= tap_src;
    s1_coef_r <= tap_coef;
    s1_centre_r <= (tap_dr_r == 2'd1) && (tap_dc_r == 2'd1);
    s2_prod_r <= s1_coef_r * $signed({1'b0, s1_data});
    if (s1_v_r && s1_centre_r) centre_r <= s1_data;
    if (fire) begin
      out_r.row      <= row_r;
      out_r.col      <= col_r;
      out_r.new_heat <= cooled;
      out_r.last     <= last_cell;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_r       <= '0;
      col_r       <= '0;
      tap_dr_r    <= '0;
      tap_dc_r    <= '0;
      bank_r      <= 1'b0;
      grid_clr_r  <= 1'b1;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < BOTTOM_SLOTS; i++) bottom_r[i] <= 8'd0;
    end else begin
      state_r  <= state_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      tap_dr_r <= tap_dr_nxt;
      tap_dc_r <= tap_dc_nxt;
      s1_v_r   <= issue;
      s2_v_r   <= s1_v_r;
      if (acc_clr) begin
        acc_r <= '0;
      end else if (s2_v_r) begin
        acc_r <= acc_r + {{3{s2_prod_r[20]}}, s2_prod_r};
      end
      if (fire && last_cell) begin
        bank_r     <= ~bank_r;
        grid_clr_r <= 1'b0;
      end
      if (job_take && !job.is_step) bottom_r[job.column] <= job.heat;
      out_valid_r <= (out_valid_r && out_stall) || fire;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH) |-> (!s1_v_r && !s2_v_r))
    else $error("finish with taps in flight");

  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.last) |-> (out_r.row == LAST_ROW && out_r.col == LAST_COL))
    else $error("last flag off the final cell");

  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_take |-> (state_r == ST_IDLE && job_valid))
    else $error("job taken while busy");

endmodule
